[hdl/rce_pkg.sv]
// Shared types and constants for the Roberts cross edge magnitude block.
// Used by the controller, the datapath and the top level. No dependencies.
package rce_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int WCFG_W     = 11;
    localparam int CFG_W      = 12;
    localparam int SQ_W       = 16;
    localparam int SUM_W      = 17;
    localparam int RAD_W      = 18;
    localparam int ROOT_W     = 9;
    localparam int REM_W      = 10;
    localparam int TRIAL_W    = 12;
    localparam int ROOT_STEPS = 9;
    localparam int STEP_W     = 4;
    localparam int RES_N      = 4;

    localparam logic IDX_WIDTH  = 1'b0;
    localparam logic IDX_HEIGHT = 1'b1;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]  HEIGHT_RESET = 12'd480;
    localparam logic [PIX_W-1:0]  MAG_MAX      = 8'd255;

    typedef struct packed {
        logic take;
        logic diff;
        logic root_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mask_empty;
        logic mask_single;
        logic out_full;
    } sts_t;

endpackage

[hdl/rce_ctrl.sv]
// Controller state machine of the Roberts cross edge magnitude block.
// Depends on rce_pkg for the command and status structs.
module rce_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_stall,
    input  rce_pkg::sts_t sts,
    output logic          in_stall,
    output rce_pkg::cmd_t cmd
);
    import rce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIFF = 4'b0010,
        S_ROOT = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                step_next  = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = sts.mask_empty ? S_IDLE : S_EMIT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_EMIT:
            begin
                if (!sts.out_full || !out_stall)
                begin
                    cmd.emit = 1'b1;
                    if (sts.mask_single)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

[hdl/rce_dp.sv]
// Datapath of the Roberts cross edge magnitude block: line store, window,
// square root unit, result sequencing and output register. Depends on rce_pkg.
module rce_dp
#(
    parameter int unsigned MAX_WIDTH = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rce_pkg::cmd_t                      cmd,
    output rce_pkg::sts_t                      sts,
    input  logic                               wr_en,
    input  logic                               wr_index,
    input  logic [rce_pkg::CFG_W-1:0]          wr_data,
    input  logic [rce_pkg::PIX_W-1:0]          pixel,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [rce_pkg::PIX_W-1:0]          magnitude,
    output logic [rce_pkg::COL_OUT_W-1:0]      out_col,
    output logic [rce_pkg::ROW_W-1:0]          out_row,
    output logic                               last
);
    import rce_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0]   row_mem [MAX_WIDTH];

    logic [WCFG_W-1:0]  width_reg;
    logic [ROW_W-1:0]   height_reg;
    logic [CW-1:0]      col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [PIX_W-1:0]   left_reg;
    logic [PIX_W-1:0]   upleft_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   rd_reg;
    logic [CW-1:0]      xm1_reg;
    logic [ROW_W-1:0]   ym1_reg;
    logic [CW-1:0]      wl_reg;
    logic [ROW_W-1:0]   hl_reg;
    logic [RES_N-1:0]   mask_reg;
    logic [RES_N-1:0]   mask_next;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   mag_reg;
    logic [PIX_W-1:0]   mag_next;
    logic [COL_OUT_W-1:0] ocol_reg;
    logic [COL_OUT_W-1:0] ocol_next;
    logic [ROW_W-1:0]   orow_reg;
    logic [ROW_W-1:0]   orow_next;
    logic               last_reg;

    logic [CW-1:0]      w_last;
    logic [ROW_W-1:0]   h_last;
    logic               end_col;
    logic               end_row;
    logic               x_nz;
    logic               y_nz;
    logic [RES_N-1:0]   mask_new;
    logic [PIX_W-1:0]   dh;
    logic [PIX_W-1:0]   dv;
    logic [SQ_W-1:0]    sq_h;
    logic [SQ_W-1:0]    sq_v;
    logic [SUM_W-1:0]   sum;
    logic [TRIAL_W-1:0] rem_t;
    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] rem_sub;
    logic               root_ge;
    logic [RES_N-1:0]   low;
    logic [PIX_W-1:0]   mag_clamp;

    // The effective frame size is the register value clamped to the legal range.
    always_comb
    begin
        if (width_reg < WCFG_W'(2))
        begin
            w_last = CW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(width_reg - WCFG_W'(1));
        end
        if (height_reg < ROW_W'(2))
        begin
            h_last = ROW_W'(1);
        end
        else
        begin
            h_last = height_reg - ROW_W'(1);
        end
    end

    assign end_col  = (col_reg >= w_last);
    assign end_row  = (row_reg >= h_last);
    assign x_nz     = (col_reg != '0);
    assign y_nz     = (row_reg != '0);
    assign mask_new = {end_row && end_col, end_row && x_nz, end_col && y_nz, x_nz && y_nz};

    assign dh   = (upleft_reg >= pix_reg) ? upleft_reg - pix_reg : pix_reg - upleft_reg;
    assign dv   = (rd_reg >= left_reg) ? rd_reg - left_reg : left_reg - rd_reg;
    assign sq_h = SQ_W'(dh) * SQ_W'(dh);
    assign sq_v = SQ_W'(dv) * SQ_W'(dv);
    assign sum  = SUM_W'(sq_h) + SUM_W'(sq_v);

    // One result bit per step, two radicand bits brought down each time.
    assign rem_t   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = (rem_t >= trial);
    assign rem_sub = rem_t - trial;

    assign mag_clamp = root_reg[ROOT_W-1] ? MAG_MAX : root_reg[PIX_W-1:0];

    assign low       = mask_reg & (~mask_reg + RES_N'(1));
    assign mask_next = mask_reg & ~low;

    always_comb
    begin
        if (low[0])
        begin
            mag_next  = mag_clamp;
            ocol_next = COL_OUT_W'(xm1_reg);
            orow_next = ym1_reg;
        end
        else if (low[1])
        begin
            mag_next  = '0;
            ocol_next = COL_OUT_W'(wl_reg);
            orow_next = ym1_reg;
        end
        else if (low[2])
        begin
            mag_next  = '0;
            ocol_next = COL_OUT_W'(xm1_reg);
            orow_next = hl_reg;
        end
        else
        begin
            mag_next  = '0;
            ocol_next = COL_OUT_W'(wl_reg);
            orow_next = hl_reg;
        end
    end

    assign sts.mask_empty  = (mask_reg == '0);
    assign sts.mask_single = ((mask_reg & (mask_reg - RES_N'(1))) == '0);
    assign sts.out_full    = out_valid_reg;

    // Line store: the old entry is read and the new pixel written on the same edge.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rd_reg           <= row_mem[col_reg];
            row_mem[col_reg] <= pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            upleft_reg    <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    IDX_WIDTH:  width_reg  <= wr_data[WCFG_W-1:0];
                    IDX_HEIGHT: height_reg <= wr_data;
                    default:    ;
                endcase
            end
            if (cmd.take)
            begin
                mask_reg <= mask_new;
                if (end_col)
                begin
                    col_reg <= '0;
                    row_reg <= end_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            else if (cmd.emit)
            begin
                mask_reg <= mask_next;
            end
            if (cmd.diff)
            begin
                upleft_reg <= rd_reg;
                left_reg   <= pix_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pix_reg <= pixel;
            xm1_reg <= col_reg - CW'(1);
            ym1_reg <= row_reg - ROW_W'(1);
            wl_reg  <= w_last;
            hl_reg  <= h_last;
        end
        if (cmd.diff)
        begin
            rad_reg  <= RAD_W'(sum);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= root_ge ? rem_sub[REM_W-1:0] : rem_t[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], root_ge};
        end
        if (cmd.emit)
        begin
            mag_reg  <= mag_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            last_reg <= sts.mask_single;
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;
    assign out_col   = ocol_reg;
    assign out_row   = orow_reg;
    assign last      = last_reg;

endmodule

[hdl/roberts_cross_edge_magnitude.sv]
// Roberts cross edge magnitude block takes one pixel word at a time and takes no
// new one until the last one's result words are issued. The nine-step square root
// loop, which brings down two bits of the sum of squares per cycle, follows the
// one-port line store read and the difference step; result words then leave one
// per cycle unless the output stalls. Results are the floor gradient magnitude
// clamped to 255, with zeros for the last column and last row, each tagged with
// its coordinates. Depends on rce_pkg, rce_ctrl and rce_dp.
module roberts_cross_edge_magnitude
#(
    parameter int unsigned MAX_WIDTH = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic                           wr_index,
    input  logic [rce_pkg::CFG_W-1:0]      wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rce_pkg::PIX_W-1:0]      pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rce_pkg::PIX_W-1:0]      magnitude,
    output logic [rce_pkg::COL_OUT_W-1:0]  out_col,
    output logic [rce_pkg::ROW_W-1:0]      out_row,
    output logic                           last
);
    import rce_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rce_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    rce_dp
    #(
        .MAX_WIDTH (MAX_WIDTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .pixel     (pixel),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .magnitude (magnitude),
        .out_col   (out_col),
        .out_row   (out_row),
        .last      (last)
    );

`ifndef ASSERT_OFF
    // A new word is never taken while the previous one is still being worked on.
    a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.diff, cmd.root_step, cmd.emit}))
        else $error("conflicting datapath commands");

    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !sts.mask_empty)
        else $error("result issued with none pending");
`endif

endmodule

[dv/rce_edge_checker.sv]
// Checker for the Roberts cross edge magnitude block: tracks the size registers,
// predicts the result words of every accepted pixel and compares them in order.
// Depends on rce_pkg.
module rce_edge_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic                           wr_index,
    input  logic [rce_pkg::CFG_W-1:0]      wr_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [rce_pkg::PIX_W-1:0]      pixel,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [rce_pkg::PIX_W-1:0]      magnitude,
    input  logic [rce_pkg::COL_OUT_W-1:0]  out_col,
    input  logic [rce_pkg::ROW_W-1:0]      out_row,
    input  logic                           last,
    output int unsigned                    outstanding,
    output int unsigned                    words_checked,
    output int unsigned                    mismatches
);

    localparam int unsigned LINE_DEPTH = 1024;

    typedef struct packed {
        logic [rce_pkg::PIX_W-1:0]     mag;
        logic [rce_pkg::COL_OUT_W-1:0] col;
        logic [rce_pkg::ROW_W-1:0]     row;
        logic                          tail;
    } edge_word_t;

    edge_word_t                  due_edges[$];
    logic [rce_pkg::PIX_W-1:0]   line_buf [0:LINE_DEPTH-1];
    logic [rce_pkg::PIX_W-1:0]   left_px;
    logic [rce_pkg::PIX_W-1:0]   upper_left_px;
    logic [rce_pkg::COL_OUT_W-1:0] col_pos;
    logic [rce_pkg::ROW_W-1:0]   row_pos;
    logic [rce_pkg::WCFG_W-1:0]  width_cfg;
    logic [rce_pkg::ROW_W-1:0]   height_cfg;

    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned r;
        int unsigned trial;
        r = 0;
        for (int k = 8; k >= 0; k--) begin
            trial = r | (32'd1 << k);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    function automatic edge_word_t make_word(input int unsigned mag, input int unsigned col,
                                             input int unsigned row);
        edge_word_t w;
        w.mag  = mag[rce_pkg::PIX_W-1:0];
        w.col  = col[rce_pkg::COL_OUT_W-1:0];
        w.row  = row[rce_pkg::ROW_W-1:0];
        w.tail = 1'b0;
        return w;
    endfunction

    task automatic advance_window(input logic [rce_pkg::PIX_W-1:0] d);
        int unsigned w, h, x, y, a, b, c, dh, dv, root, n;
        logic        end_c, end_r;
        edge_word_t  batch [4];
        edge_word_t  word;
        w = width_cfg;
        if (w < 2)
            w = 2;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        h = height_cfg;
        if (h < 2)
            h = 2;
        x = col_pos;
        y = row_pos;
        end_c = (x >= w - 1);
        end_r = (y >= h - 1);
        a = upper_left_px;
        b = line_buf[x];
        c = left_px;
        n = 0;
        if (x >= 1 && y >= 1)
        begin
            dh = (a >= d) ? a - d : d - a;
            dv = (b >= c) ? b - c : c - b;
            root = floor_root(dh * dh + dv * dv);
            if (root > 255)
                root = 255;
            batch[n] = make_word(root, x - 1, y - 1);
            n++;
        end
        if (end_c && y >= 1)
        begin
            batch[n] = make_word(0, w - 1, y - 1);
            n++;
        end
        if (end_r && x >= 1)
        begin
            batch[n] = make_word(0, x - 1, h - 1);
            n++;
        end
        if (end_r && end_c)
        begin
            batch[n] = make_word(0, w - 1, h - 1);
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            word = batch[i];
            word.tail = (i == n - 1);
            due_edges.push_back(word);
        end
        line_buf[x] = d;
        upper_left_px = b[rce_pkg::PIX_W-1:0];
        left_px = d;
        if (end_c)
        begin
            col_pos = '0;
            row_pos = end_r ? '0 : row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic check_word();
        edge_word_t want;
        if (due_edges.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected word: mag=%0d col=%0d row=%0d last=%0b",
                         magnitude, out_col, out_row, last);
        end
        else
        begin
            want = due_edges.pop_front();
            words_checked++;
            if (magnitude !== want.mag || out_col !== want.col ||
                out_row !== want.row || last !== want.tail)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected mag=%0d col=%0d row=%0d last=%0b, got mag=%0d col=%0d row=%0d last=%0b",
                             want.mag, want.col, want.row, want.tail,
                             magnitude, out_col, out_row, last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_edges.delete();
            for (int i = 0; i < LINE_DEPTH; i++)
                line_buf[i] = '0;
            left_px = '0;
            upper_left_px = '0;
            col_pos = '0;
            row_pos = '0;
            width_cfg = rce_pkg::WIDTH_RESET;
            height_cfg = rce_pkg::HEIGHT_RESET;
            outstanding = 0;
            words_checked = 0;
            mismatches = 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == rce_pkg::IDX_WIDTH)
                    width_cfg = wr_data[rce_pkg::WCFG_W-1:0];
                else
                    height_cfg = wr_data;
            end
            if (out_valid && !out_stall)
                check_word();
            if (in_valid && !in_stall)
                advance_window(pixel);
            outstanding = due_edges.size();
        end
    end

endmodule

[dv/roberts_cross_edge_magnitude_tb.sv]
// Testbench top for the Roberts cross edge magnitude block: drives pixel frames,
// size register writes and output stalls, and reports the verdict.
// Depends on rce_pkg, roberts_cross_edge_magnitude and rce_edge_checker.
module roberts_cross_edge_magnitude_tb;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned RANDOM_PIXELS = 200;

    typedef enum int unsigned {FILL_NOISE, FILL_EXTREME, FILL_SMOOTH} fill_t;

    logic                           clk;
    logic                           rst_n;
    logic                           wr_en;
    logic                           wr_index;
    logic [rce_pkg::CFG_W-1:0]      wr_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [rce_pkg::PIX_W-1:0]      pixel;
    logic                           out_valid;
    logic                           out_stall;
    logic [rce_pkg::PIX_W-1:0]      magnitude;
    logic [rce_pkg::COL_OUT_W-1:0]  out_col;
    logic [rce_pkg::ROW_W-1:0]      out_row;
    logic                           last;

    int unsigned outstanding;
    int unsigned words_checked;
    int unsigned mismatches;
    int unsigned cycles = 0;
    int unsigned pixels_sent = 0;
    int unsigned shapes_run = 0;
    int unsigned burst_left = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;

    logic [rce_pkg::PIX_W-1:0] corner_px [24] = '{
        8'd255, 8'd0,   8'd255, 8'd0,
        8'd0,   8'd255, 8'd0,   8'd255,
        8'd255, 8'd0,   8'd0,   8'd255,
        8'd180, 8'd0,   8'd0,   8'd0,
        8'd7,   8'd0,   8'd0,   8'd9,
        8'd255, 8'd255, 8'd255, 8'd255
    };

    roberts_cross_edge_magnitude u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .magnitude (magnitude),
        .out_col   (out_col),
        .out_row   (out_row),
        .last      (last)
    );

    rce_edge_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .magnitude     (magnitude),
        .out_col       (out_col),
        .out_row       (out_row),
        .last          (last),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words still due.",
                     cycles, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver changes its stall pattern every segment; a requested hold
    // keeps it stalled long enough for the block to back up into its input.
    initial
    begin
        int unsigned seg;
        int unsigned mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (holds_done < holds_asked)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                seg = $urandom_range(10, 150);
                for (int i = 0; i < seg; i++)
                begin
                    case (mode)
                        0: out_stall = 1'b0;
                        1: out_stall = ($urandom_range(0, 3) == 0);
                        2: out_stall = ($urandom_range(0, 9) < 7);
                        default: out_stall = (i % 3 == 0);
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    task automatic send_pixel(input logic [rce_pkg::PIX_W-1:0] p);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 18);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid = 1'b1;
        pixel = p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        pixels_sent++;
    endtask

    function automatic logic [rce_pkg::PIX_W-1:0] pick_pixel(input fill_t fill);
        case (fill)
            FILL_EXTREME: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            FILL_SMOOTH:  return 8'($urandom_range(118, 138));
            default:      return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixels(input int unsigned count, input fill_t fill);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(pick_pixel(fill));
    endtask

    task automatic write_sizes(input logic [rce_pkg::CFG_W-1:0] w_data,
                               input logic [rce_pkg::CFG_W-1:0] h_data);
        wr_en = 1'b1;
        wr_index = rce_pkg::IDX_WIDTH;
        wr_data = w_data;
        @(negedge clk);
        wr_index = rce_pkg::IDX_HEIGHT;
        wr_data = h_data;
        @(negedge clk);
        wr_en = 1'b0;
        shapes_run++;
    endtask

    task automatic settle();
        in_valid = 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned random_count;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned frames;
        logic [rce_pkg::CFG_W-1:0] w_raw;
        logic [rce_pkg::CFG_W-1:0] h_raw;
        fill_t fill;

        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = rce_pkg::IDX_WIDTH;
        wr_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Start a row at the reset sizes, then shrink the width so that the
        // current column is already past the end of the row.
        send_pixels(6, FILL_NOISE);
        settle();
        write_sizes(12'd3, 12'd2);
        send_pixels(4, FILL_NOISE);
        settle();

        // Stop inside the fourth row, then shrink both sizes so that the next
        // pixel closes its row and the frame and gives all four result words.
        write_sizes(12'd6, 12'd5);
        send_pixels(20, FILL_NOISE);
        settle();
        write_sizes(12'd3, 12'd2);
        send_pixel(8'd200);
        settle();

        write_sizes(12'd2, 12'd2);
        foreach (corner_px[i])
            send_pixel(corner_px[i]);
        settle();

        // Out-of-range sizes clamp to the smallest frame, masked bits included.
        write_sizes(12'd0, 12'd1);
        send_pixels(8, FILL_EXTREME);
        settle();
        write_sizes(12'h801, 12'd0);
        send_pixels(4, FILL_NOISE);
        settle();

        // The widest and the tallest settings, each cut short by a later write.
        write_sizes(12'hFFF, 12'd2);
        send_pixels(20, FILL_NOISE);
        settle();
        write_sizes(12'd3, 12'd2);
        send_pixels(4, FILL_NOISE);
        settle();
        write_sizes(12'd2, 12'd4095);
        send_pixels(10, FILL_NOISE);
        settle();
        write_sizes(12'd2, 12'd2);
        send_pixels(2, FILL_NOISE);
        settle();

        holds_asked = 1;
        random_count = 0;
        while (random_count < RANDOM_PIXELS)
        begin
            w_eff = $urandom_range(2, 9);
            w_raw = 12'(w_eff);
            w_raw[11] = $urandom_range(0, 1);
            if (w_eff == 2 && $urandom_range(0, 1) == 1)
                w_raw[10:0] = 11'($urandom_range(0, 1));
            h_eff = $urandom_range(2, 6);
            h_raw = 12'(h_eff);
            if (h_eff == 2 && $urandom_range(0, 1) == 1)
                h_raw = 12'($urandom_range(0, 1));
            frames = $urandom_range(1, 2);
            case ($urandom_range(0, 5))
                0: fill = FILL_EXTREME;
                1: fill = FILL_SMOOTH;
                default: fill = FILL_NOISE;
            endcase
            write_sizes(w_raw, h_raw);
            send_pixels(w_eff * h_eff * frames, fill);
            settle();
            random_count += w_eff * h_eff * frames;
            if (random_count > RANDOM_PIXELS / 2 && holds_asked < 2)
                holds_asked = 2;
        end

        $display("Sent %0d pixels over %0d size settings, with clamped and mid-frame sizes.",
                 pixels_sent, shapes_run);
        $display("Checked %0d result words, %0d mismatches, %0d long output holds.",
                 words_checked, mismatches, holds_done);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/rce_pkg.sv
hdl/rce_ctrl.sv
hdl/rce_dp.sv
hdl/roberts_cross_edge_magnitude.sv
dv/rce_edge_checker.sv
dv/roberts_cross_edge_magnitude_tb.sv
